// ===== design/iirdf2_pkg.sv =====
`timescale 1ns / 1ps
// Package for the order-2 direct-form-II IIR filter.
// Holds widths, register indexes, the control word type and the microcode ROM.
package iirdf2_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 16;
  localparam int W_W       = 24;
  localparam int FRAC_BITS = 14;
  localparam int PROD_W    = COEF_W + W_W;
  localparam int TERM_W    = PROD_W - FRAC_BITS;
  localparam int ACC_W     = TERM_W + 2;
  localparam int STEP_W    = 3;
  localparam int CFG_IDX_W = 3;

  localparam logic signed [COEF_W-1:0] IN_GAIN_RESET  = 16'sd16384;
  localparam logic signed [COEF_W-1:0] OUT_GAIN_RESET = 16'sd16384;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_GAIN     = 3'd0,
    REG_FB_COEF_ONE = 3'd1,
    REG_FB_COEF_TWO = 3'd2,
    REG_OUT_GAIN    = 3'd3,
    REG_FF_COEF_ONE = 3'd4,
    REG_FF_COEF_TWO = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    C_IN_GAIN,
    C_FB_ONE,
    C_FB_TWO,
    C_OUT_GAIN,
    C_FF_ONE,
    C_FF_TWO,
    C_ZERO
  } coef_sel_t;

  typedef enum logic [1:0] {
    D_X,
    D_D0,
    D_D1,
    D_W
  } data_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  typedef enum logic [1:0] {
    COND_NONE,
    COND_IN,
    COND_OUT
  } cond_t;

  typedef struct packed {
    coef_sel_t coef;
    data_sel_t dsel;
    acc_op_t   accw_op;
    acc_op_t   accy_op;
    logic      w_ld;
    logic      emit;
    cond_t     cond;
    logic      jump;
    step_t     target;
  } ctrl_t;

  // Step 0 waits for a sample, step 7 waits for room in the output register.
  function automatic ctrl_t ucode(step_t step);
    ctrl_t c;
    c = '{coef: C_ZERO, dsel: D_X, accw_op: ACC_HOLD, accy_op: ACC_HOLD,
          w_ld: 1'b0, emit: 1'b0, cond: COND_NONE, jump: 1'b0, target: '0};
    unique case (step)
      3'd0: begin
        c.coef = C_IN_GAIN;  c.dsel = D_X;  c.cond = COND_IN;
      end
      3'd1: begin
        c.coef = C_FB_ONE;   c.dsel = D_D0; c.accw_op = ACC_LOAD;
      end
      3'd2: begin
        c.coef = C_FB_TWO;   c.dsel = D_D1; c.accw_op = ACC_ADD;
      end
      3'd3: begin
        c.coef = C_FF_ONE;   c.dsel = D_D0; c.accw_op = ACC_ADD;
      end
      3'd4: begin
        c.coef = C_FF_TWO;   c.dsel = D_D1; c.accy_op = ACC_LOAD; c.w_ld = 1'b1;
      end
      3'd5: begin
        c.coef = C_OUT_GAIN; c.dsel = D_W;  c.accy_op = ACC_ADD;
      end
      3'd6: begin
        c.accy_op = ACC_ADD;
      end
      3'd7: begin
        c.emit = 1'b1; c.cond = COND_OUT; c.jump = 1'b1; c.target = '0;
      end
    endcase
    return c;
  endfunction

endpackage

// ===== design/iirdf2_if.sv =====
`timescale 1ns / 1ps
// Valid/ready sample channels for the IIR filter.
// Depends on iirdf2_pkg for the sample width.
interface iirdf2_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [iirdf2_pkg::SAMPLE_W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface iirdf2_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [iirdf2_pkg::SAMPLE_W-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

// ===== design/iir_direct_form_two_filter.sv =====
`timescale 1ns / 1ps
// Order-2 direct-form-II IIR filter, Q2.14 coefficients, one shared 16x24 MAC.
// The input is taken at step 0; the result reaches the output register at step 7.
// The eight-step microcode on the single multiplier takes a new sample only at step 0,
// after the last one is emitted; step 7 holds while the output register is still full.
// Reset: coefficients to defaults, delay line zeroed, sequencer at step 0.
module iir_direct_form_two_filter #(
  parameter int ORDER = 2
) (
  input  logic                                 clk,
  input  logic                                 rst,
  iirdf2_in_if.sink                            in_chan,
  iirdf2_out_if.source                         out_chan,
  input  logic                                 cfg_write,
  input  logic [iirdf2_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [iirdf2_pkg::COEF_W-1:0]        cfg_data
);

  localparam int SAMPLE_W  = iirdf2_pkg::SAMPLE_W;
  localparam int COEF_W    = iirdf2_pkg::COEF_W;
  localparam int W_W       = iirdf2_pkg::W_W;
  localparam int PROD_W    = iirdf2_pkg::PROD_W;
  localparam int ACC_W     = iirdf2_pkg::ACC_W;
  localparam int FRAC_BITS = iirdf2_pkg::FRAC_BITS;
  localparam int D1_IDX    = (ORDER > 1) ? 1 : 0;

  logic signed [COEF_W-1:0] in_gain, fb_coef_one, fb_coef_two;
  logic signed [COEF_W-1:0] out_gain, ff_coef_one, ff_coef_two;

  logic signed [W_W-1:0]    delay_line [ORDER];
  logic signed [W_W-1:0]    w;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  accw, accy;

  iirdf2_pkg::step_t step, step_next;
  iirdf2_pkg::ctrl_t ctrl;

  logic                     out_free, stall, emit_go;
  logic signed [COEF_W-1:0] coef_mux;
  logic signed [W_W-1:0]    data_mux, d1_val, w_sat;
  logic signed [PROD_W-1:0] prod_rnd;
  logic signed [ACC_W-1:0]  term;
  logic [ACC_W-W_W:0]       w_hi;
  logic [ACC_W-SAMPLE_W:0]  y_hi;
  logic signed [SAMPLE_W-1:0] y_sat;

  // Configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      in_gain     <= iirdf2_pkg::IN_GAIN_RESET;
      fb_coef_one <= '0;
      fb_coef_two <= '0;
      out_gain    <= iirdf2_pkg::OUT_GAIN_RESET;
      ff_coef_one <= '0;
      ff_coef_two <= '0;
    end else if (cfg_write) begin
      case (iirdf2_pkg::cfg_reg_t'(cfg_index))
        iirdf2_pkg::REG_IN_GAIN:     in_gain     <= cfg_data;
        iirdf2_pkg::REG_FB_COEF_ONE: fb_coef_one <= cfg_data;
        iirdf2_pkg::REG_FB_COEF_TWO: fb_coef_two <= cfg_data;
        iirdf2_pkg::REG_OUT_GAIN:    out_gain    <= cfg_data;
        iirdf2_pkg::REG_FF_COEF_ONE: ff_coef_one <= cfg_data;
        iirdf2_pkg::REG_FF_COEF_TWO: ff_coef_two <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer
  assign ctrl     = iirdf2_pkg::ucode(step);
  assign out_free = !out_chan.valid || out_chan.ready;
  assign in_chan.ready = (ctrl.cond == iirdf2_pkg::COND_IN);
  assign emit_go  = ctrl.emit && out_free;

  always_comb begin
    stall = 1'b0;
    case (ctrl.cond)
      iirdf2_pkg::COND_IN:  stall = !in_chan.valid;
      iirdf2_pkg::COND_OUT: stall = !out_free;
      default:              stall = 1'b0;
    endcase
  end

  always_comb begin
    if (stall) begin
      step_next = step;
    end else if (ctrl.jump) begin
      step_next = ctrl.target;
    end else begin
      step_next = step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else begin
      step <= step_next;
    end
  end

  // Operand selection; taps past the second carry no coefficient
  assign d1_val = (ORDER > 1) ? delay_line[D1_IDX] : '0;

  always_comb begin
    coef_mux = '0;
    case (ctrl.coef)
      iirdf2_pkg::C_IN_GAIN:  coef_mux = in_gain;
      iirdf2_pkg::C_FB_ONE:   coef_mux = fb_coef_one;
      iirdf2_pkg::C_FB_TWO:   coef_mux = fb_coef_two;
      iirdf2_pkg::C_OUT_GAIN: coef_mux = out_gain;
      iirdf2_pkg::C_FF_ONE:   coef_mux = ff_coef_one;
      iirdf2_pkg::C_FF_TWO:   coef_mux = ff_coef_two;
      default:                coef_mux = '0;
    endcase
  end

  always_comb begin
    data_mux = '0;
    case (ctrl.dsel)
      iirdf2_pkg::D_X:  data_mux = W_W'(in_chan.sample_in);
      iirdf2_pkg::D_D0: data_mux = delay_line[0];
      iirdf2_pkg::D_D1: data_mux = d1_val;
      iirdf2_pkg::D_W:  data_mux = w;
      default:          data_mux = '0;
    endcase
  end

  // MAC: registered product, round half up to sample scale, accumulate
  always_ff @(posedge clk) begin
    prod <= PROD_W'(coef_mux) * PROD_W'(data_mux);
  end

  assign prod_rnd = prod + (PROD_W'(1) <<< (FRAC_BITS - 1));
  assign term     = ACC_W'($signed(prod_rnd[PROD_W-1:FRAC_BITS]));

  always_ff @(posedge clk) begin
    case (ctrl.accw_op)
      iirdf2_pkg::ACC_LOAD: accw <= term;
      iirdf2_pkg::ACC_ADD:  accw <= accw + term;
      default:              accw <= accw;
    endcase
    case (ctrl.accy_op)
      iirdf2_pkg::ACC_LOAD: accy <= term;
      iirdf2_pkg::ACC_ADD:  accy <= accy + term;
      default:              accy <= accy;
    endcase
  end

  // Saturation
  assign w_hi = accw[ACC_W-1:W_W-1];
  assign y_hi = accy[ACC_W-1:SAMPLE_W-1];

  always_comb begin
    if (w_hi != '0 && w_hi != '1) begin
      w_sat = accw[ACC_W-1] ? {1'b1, {(W_W-1){1'b0}}} : {1'b0, {(W_W-1){1'b1}}};
    end else begin
      w_sat = accw[W_W-1:0];
    end
    if (y_hi != '0 && y_hi != '1) begin
      y_sat = accy[ACC_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      y_sat = accy[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.w_ld) begin
      w <= w_sat;
    end
  end

  // Delay line, newest first
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ORDER; k++) begin
        delay_line[k] <= '0;
      end
    end else if (emit_go) begin
      delay_line[0] <= w;
      for (int k = 1; k < ORDER; k++) begin
        delay_line[k] <= delay_line[k-1];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_chan.valid <= 1'b0;
    end else if (emit_go) begin
      out_chan.valid <= 1'b1;
    end else if (out_chan.ready) begin
      out_chan.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_chan.sample_out <= y_sat;
    end
  end

endmodule
